[rtl/core/khr_pkg.sv]
// ----------------------------------------------------------------------------
// khr_pkg
// Shared constants, codes and payload types of the key scan to boot report
// block.
// ----------------------------------------------------------------------------
package khr_pkg;

    // keymap geometry
    localparam int HALF_KEYS   = 64;
    localparam int SIDE_SPAN   = 64;
    localparam int LOCAL_W     = $clog2(SIDE_SPAN);
    localparam int STORE_DEPTH = 2 * SIDE_SPAN;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // frame accumulation
    localparam int          SLOT_COUNT  = 6;
    localparam int          SLOT_W      = 3;
    localparam int          COUNT_W     = 9;
    localparam logic [8:0]  COUNTER_CAP = 9'd256;
    localparam logic [7:0]  NONE_MARK   = 8'hFF;

    // item operations
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam int   CFG_INDEX_W     = 1;
    localparam logic REG_PRESS_LEVEL = 1'b0;
    localparam logic REG_SWAP_SIDES  = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [6:0]  entry_address;
        logic        entry_valid;
        logic [7:0]  entry_usage;
        logic [7:0]  entry_modifier;
        logic [15:0] sample_level;
        logic        last_in_frame;
    } item_t;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
        logic       key_down;
        logic [7:0] first_src;
        logic [7:0] first_key;
    } report_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] usage;
        logic [7:0] modifier;
    } map_entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        map_entry_t        entry;
    } keymap_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } keymap_rd_t;

    // sample in flight between keymap read and accumulation
    typedef struct packed {
        logic       hit;
        logic       last;
        logic [7:0] source;
        logic [7:0] key_pos;
    } sample_t;

endpackage

[rtl/core/khr_keymap.sv]
// ----------------------------------------------------------------------------
// khr_keymap
// Keymap store: usage and modifier in a synchronous memory, valid bits in
// flip-flops cleared by reset; one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module khr_keymap (
    input  logic                clk,
    input  logic                rst_n,
    input  khr_pkg::keymap_wr_t wr,
    input  khr_pkg::keymap_rd_t rd,
    output khr_pkg::map_entry_t entry
);
    import khr_pkg::*;

    logic [15:0]            mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [15:0]            rd_data_reg;
    logic                   rd_valid_reg;

    // payload memory, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= {wr.entry.usage, wr.entry.modifier};
        end
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    // per-entry valid bits, all invalid after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= wr.entry.valid;
            end
            if (rd.en)
            begin
                rd_valid_reg <= valid_reg[rd.addr];
            end
        end
    end

    assign entry.valid    = rd_valid_reg;
    assign entry.usage    = rd_data_reg[15:8];
    assign entry.modifier = rd_data_reg[7:0];

endmodule

[rtl/core/khr_report.sv]
// ----------------------------------------------------------------------------
// khr_report
// Frame accumulator: merges one looked-up sample per cycle while step is high
// into the modifier byte, the six usage slots and the first-pressed record.
// ----------------------------------------------------------------------------
module khr_report (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  khr_pkg::sample_t    sample,
    input  khr_pkg::map_entry_t entry,
    output khr_pkg::report_t    frame_report
);
    import khr_pkg::*;

    logic [7:0]        modifier_reg, modifier_next;
    logic [7:0]        slot_reg  [SLOT_COUNT];
    logic [7:0]        slot_next [SLOT_COUNT];
    logic [SLOT_W-1:0] filled_reg, filled_next;
    logic              pressed_reg, pressed_next;
    logic [7:0]        first_source_reg, first_source_next;
    logic [7:0]        first_local_reg, first_local_next;
    logic              hit;
    logic              present;
    logic              take;

    // duplicate check against filled slots
    always_comb
    begin
        hit     = sample.hit && entry.valid;
        present = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if ((SLOT_W'(i) < filled_reg) && (slot_reg[i] == entry.usage))
            begin
                present = 1'b1;
            end
        end
        take = hit && (entry.usage != 8'd0) && !present
            && (filled_reg < SLOT_W'(SLOT_COUNT));
    end

    // accumulator update
    always_comb
    begin
        modifier_next     = modifier_reg | (hit ? entry.modifier : 8'd0);
        pressed_next      = pressed_reg | hit;
        first_source_next = first_source_reg;
        first_local_next  = first_local_reg;
        if (hit && !pressed_reg)
        begin
            first_source_next = sample.source;
            first_local_next  = sample.key_pos;
        end
        filled_next = take ? filled_reg + SLOT_W'(1) : filled_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            slot_next[i] = (take && (filled_reg == SLOT_W'(i))) ? entry.usage : slot_reg[i];
        end
    end

    // accumulator registers, cleared at the end of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg     <= 8'd0;
            filled_reg       <= '0;
            pressed_reg      <= 1'b0;
            first_source_reg <= NONE_MARK;
            first_local_reg  <= NONE_MARK;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_reg[i] <= 8'd0;
            end
        end
        else if (step)
        begin
            if (sample.last)
            begin
                modifier_reg     <= 8'd0;
                filled_reg       <= '0;
                pressed_reg      <= 1'b0;
                first_source_reg <= NONE_MARK;
                first_local_reg  <= NONE_MARK;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slot_reg[i] <= 8'd0;
                end
            end
            else
            begin
                modifier_reg     <= modifier_next;
                filled_reg       <= filled_next;
                pressed_reg      <= pressed_next;
                first_source_reg <= first_source_next;
                first_local_reg  <= first_local_next;
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    slot_reg[i] <= slot_next[i];
                end
            end
        end
    end

    // report as it stands after this sample
    assign frame_report.modifier_bits = modifier_next;
    assign frame_report.key_slot_0    = slot_next[0];
    assign frame_report.key_slot_1    = slot_next[1];
    assign frame_report.key_slot_2    = slot_next[2];
    assign frame_report.key_slot_3    = slot_next[3];
    assign frame_report.key_slot_4    = slot_next[4];
    assign frame_report.key_slot_5    = slot_next[5];
    assign frame_report.key_down      = pressed_next;
    assign frame_report.first_src     = first_source_next;
    assign frame_report.first_key     = first_local_next;

endmodule

[rtl/core/key_scan_to_hid_boot_report.sv]
// ----------------------------------------------------------------------------
// key_scan_to_hid_boot_report
// Builds one USB HID boot keyboard report per scan frame of key levels.
// ----------------------------------------------------------------------------
// Takes one request per clock, loads and samples alike, for as long as the
// report register is free or being drained. A sample reads its keymap entry
// from the synchronous keymap memory in the cycle it is accepted; the lookup
// stage register then hands it to the frame accumulators when that stage
// steps, and the report register loads as the last sample of a frame is
// merged. The only stall is a new frame end meeting a report not yet taken.
// The keymap valid bits clear at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module key_scan_to_hid_boot_report (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  khr_pkg::item_t                      item,
    output logic                                report_valid,
    input  logic                                report_ready,
    output khr_pkg::report_t                    report,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [khr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);
    import khr_pkg::*;

    logic [15:0]        threshold_reg;
    logic               swap_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               s1_valid_reg;
    sample_t            s1_reg, s1_next;
    report_t            report_reg;
    logic               report_valid_reg;
    report_t            frame_report;
    keymap_wr_t         wr;
    keymap_rd_t         rd;
    map_entry_t         entry;
    logic               stall;
    logic               accept;
    logic               sample_acc;
    logic               step;
    logic [7:0]         idx;
    logic [7:0]         local_full;
    logic               side;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 16'd0;
            swap_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRESS_LEVEL: threshold_reg <= cfg_data;
                REG_SWAP_SIDES:  swap_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // request handshake
    assign stall      = s1_valid_reg && s1_reg.last && report_valid_reg && !report_ready;
    assign item_ready = !stall;
    assign accept     = item_valid && item_ready;
    assign sample_acc = accept && (item.operation == OP_SAMPLE);
    assign step       = s1_valid_reg && !stall;

    // frame index decode and keymap address
    always_comb
    begin
        idx             = count_reg[7:0];
        local_full      = 8'(idx % HALF_KEYS);
        s1_next.source  = 8'(idx / HALF_KEYS);
        s1_next.key_pos = local_full;
        s1_next.last    = item.last_in_frame;
        s1_next.hit     = !count_reg[COUNT_W-1]
            && (item.sample_level >= threshold_reg)
            && (32'(local_full) < SIDE_SPAN);
        side            = (s1_next.source != 8'd0) ^ swap_reg;
        rd.en           = sample_acc;
        rd.addr         = ADDR_W'({side, local_full[LOCAL_W-1:0]});
        wr.en           = accept && (item.operation == OP_LOAD);
        wr.addr         = item.entry_address[ADDR_W-1:0];
        wr.entry.valid    = item.entry_valid;
        wr.entry.usage    = item.entry_usage;
        wr.entry.modifier = item.entry_modifier;
    end

    // saturating sample counter, restarts after the frame end
    always_comb
    begin
        count_next = count_reg;
        if (sample_acc)
        begin
            if (item.last_in_frame)
            begin
                count_next = '0;
            end
            else if (count_reg != COUNTER_CAP)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    // counter and lookup stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (!stall)
            begin
                s1_valid_reg <= sample_acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    khr_keymap u_keymap (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .entry (entry)
    );

    khr_report u_report (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .sample       (s1_reg),
        .entry        (entry),
        .frame_report (frame_report)
    );

    // report output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (step && s1_reg.last)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && s1_reg.last)
        begin
            report_reg <= frame_report;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

endmodule

[rtl/core/khr_checker.sv]
// ----------------------------------------------------------------------------
// khr_checker
// Port-level checks of the boot report block, bound to the top level.
// ----------------------------------------------------------------------------
module khr_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_ready,
    input  khr_pkg::item_t                      item,
    input  logic                                report_valid,
    input  logic                                report_ready,
    input  khr_pkg::report_t                    report,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);
    import khr_pkg::*;

    // a pending report holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(report))
        else $error("report dropped or changed while stalled");

    // a new report only follows an accepted frame-ending sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(report_valid) |->
            $past(item_valid && item_ready && (item.operation == OP_SAMPLE)
                  && item.last_in_frame, 2))
        else $error("report without a frame end");

    // requests are only held off behind an untaken report
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> report_valid && !report_ready)
        else $error("request stalled without output backpressure");

    // an idle frame reports nothing pressed
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report.key_down |->
            (report.modifier_bits == 8'd0) && (report.key_slot_0 == 8'd0)
            && (report.first_src == NONE_MARK)
            && (report.first_key == NONE_MARK))
        else $error("empty frame report carries key data");

    // configuration is never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind key_scan_to_hid_boot_report khr_checker u_khr_checker (.*);

[verif/key_scan_to_hid_boot_report_tb.sv]
// ----------------------------------------------------------------------------
// key_scan_to_hid_boot_report_tb
// Self-checking bench for the key scan to boot keyboard report block. Keymap
// loads and key samples go in over a randomly paced request channel, and a
// scoreboard builds the report that each frame must produce. Reports are taken
// with random stalls and compared field by field in order.
// ----------------------------------------------------------------------------
module key_scan_to_hid_boot_report_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import khr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int ITEM_TARGET    = 1350;

    // report predictor and store of reports still owed by the block
    class hid_report_scoreboard;
        map_entry_t  keymap [STORE_DEPTH];
        logic [15:0] press_level;
        logic        swap_sides;
        int          frame_index;
        logic [7:0]  modifier_accum;
        logic [7:0]  usage_slots [SLOT_COUNT];
        int          slots_filled;
        logic        pressed;
        logic [7:0]  first_source;
        logic [7:0]  first_local;
        report_t     expected_reports [$];
        int          mismatch_count;

        function new();
            foreach (keymap[i])
                keymap[i] = '0;
            press_level    = '0;
            swap_sides     = 1'b0;
            mismatch_count = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_index    = 0;
            modifier_accum = '0;
            foreach (usage_slots[i])
                usage_slots[i] = '0;
            slots_filled   = 0;
            pressed        = 1'b0;
            first_source   = NONE_MARK;
            first_local    = NONE_MARK;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [15:0] data);
            if (index == REG_PRESS_LEVEL)
                press_level = data;
            else if (index == REG_SWAP_SIDES)
                swap_sides = data[0];
        endfunction

        // fold one accepted request into the frame, queue a report on frame end
        function void note_request(input item_t req);
            int         source;
            int         key_pos;
            int         side;
            map_entry_t ent;
            bit         seen;
            report_t    rpt;
            if (req.operation == OP_LOAD)
            begin
                keymap[req.entry_address] =
                    {req.entry_valid, req.entry_usage, req.entry_modifier};
                return;
            end
            // only the first 256 frame positions are looked up
            if (frame_index < COUNTER_CAP && req.sample_level >= press_level)
            begin
                source  = frame_index / HALF_KEYS;
                key_pos = frame_index % HALF_KEYS;
                side    = (source == 0) ? 0 : 1;
                if (swap_sides)
                    side = side ^ 1;
                ent = keymap[(side * SIDE_SPAN + key_pos) % STORE_DEPTH];
                if (key_pos < SIDE_SPAN && ent.valid)
                begin
                    if (!pressed)
                    begin
                        first_source = source[7:0];
                        first_local  = key_pos[7:0];
                    end
                    pressed        = 1'b1;
                    modifier_accum = modifier_accum | ent.modifier;
                    seen = 1'b0;
                    for (int i = 0; i < slots_filled; i++)
                        if (usage_slots[i] == ent.usage)
                            seen = 1'b1;
                    // zero usage, repeats and a full report take no slot
                    if (ent.usage != 8'd0 && !seen && slots_filled < SLOT_COUNT)
                    begin
                        usage_slots[slots_filled] = ent.usage;
                        slots_filled++;
                    end
                end
            end
            if (frame_index < COUNTER_CAP)
                frame_index++;
            if (req.last_in_frame)
            begin
                rpt.modifier_bits = modifier_accum;
                rpt.key_slot_0    = usage_slots[0];
                rpt.key_slot_1    = usage_slots[1];
                rpt.key_slot_2    = usage_slots[2];
                rpt.key_slot_3    = usage_slots[3];
                rpt.key_slot_4    = usage_slots[4];
                rpt.key_slot_5    = usage_slots[5];
                rpt.key_down      = pressed;
                rpt.first_src     = first_source;
                rpt.first_key     = first_local;
                expected_reports.push_back(rpt);
                clear_frame();
            end
        endfunction

        task report_mismatch(input string msg);
            $display("%0t ns: mismatch: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_field(input string name, input logic [7:0] got,
                         input logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        // compare one accepted report with the oldest one owed
        task check_report(input report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("report %h with none owed", got));
                return;
            end
            want = expected_reports.pop_front();
            check_field("modifier_bits", got.modifier_bits, want.modifier_bits);
            check_field("key_slot_0", got.key_slot_0, want.key_slot_0);
            check_field("key_slot_1", got.key_slot_1, want.key_slot_1);
            check_field("key_slot_2", got.key_slot_2, want.key_slot_2);
            check_field("key_slot_3", got.key_slot_3, want.key_slot_3);
            check_field("key_slot_4", got.key_slot_4, want.key_slot_4);
            check_field("key_slot_5", got.key_slot_5, want.key_slot_5);
            check_field("key_down", 8'(got.key_down), 8'(want.key_down));
            check_field("first_src", got.first_src, want.first_src);
            check_field("first_key", got.first_key, want.first_key);
        endtask
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   item_valid   = 1'b0;
    logic                   item_ready;
    item_t                  item         = '0;
    logic                   report_valid;
    logic                   report_ready = 1'b0;
    report_t                report;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [15:0]            cfg_data     = '0;

    hid_report_scoreboard board;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    int items_sent  = 0;
    int frames_done = 0;
    int idle_cycles = 0;

    key_scan_to_hid_boot_report i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .report       (report),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // unused fields of each request carry random bits
    function automatic item_t make_load(input logic [6:0] addr, input logic valid,
                                        input logic [7:0] usage,
                                        input logic [7:0] modifier);
        logic [63:0] raw;
        item_t       req;
        raw = {$urandom(), $urandom()};
        req = raw[$bits(item_t)-1:0];
        req.operation      = OP_LOAD;
        req.entry_address  = addr;
        req.entry_valid    = valid;
        req.entry_usage    = usage;
        req.entry_modifier = modifier;
        return req;
    endfunction

    function automatic item_t make_sample(input logic [15:0] level,
                                          input logic ends_frame);
        logic [63:0] raw;
        item_t       req;
        raw = {$urandom(), $urandom()};
        req = raw[$bits(item_t)-1:0];
        req.operation     = OP_SAMPLE;
        req.sample_level  = level;
        req.last_in_frame = ends_frame;
        return req;
    endfunction

    // small usage pool so repeats and slot overflow happen often
    function automatic item_t random_load();
        logic [7:0] usage;
        logic [7:0] modifier;
        usage    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 10));
        modifier = ($urandom_range(0, 1) == 0) ? 8'(1 << $urandom_range(0, 7))
                                               : 8'($urandom_range(0, 255));
        return make_load(7'($urandom_range(0, 127)), $urandom_range(0, 3) != 0,
                         usage, modifier);
    endfunction

    // levels cluster on the threshold edges and the range ends
    function automatic logic [15:0] pick_level(input logic [15:0] thr);
        case ($urandom_range(0, 5))
            0:       return thr;
            1:       return thr - 16'd1;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one request; valid stays high after acceptance for a back-to-back follower
    task automatic send_request(input item_t req);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        board.note_request(req);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_register(index, data);
    endtask

    // hold off until every owed report is in and the pipeline has settled
    task automatic drain();
        item_valid <= 1'b0;
        while (board.expected_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [15:0] thr;
        logic        swap;
        int          frame_len;
        int          pick;
        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: threshold edges, invalid entry, zero and repeated usage
        write_reg(REG_PRESS_LEVEL, 16'h8000);
        write_reg(REG_SWAP_SIDES, 16'h0000);
        cfg_valid <= 1'b0;
        send_request(make_load(7'd0, 1'b1, 8'hFF, 8'h80));
        send_request(make_load(7'd1, 1'b1, 8'hFF, 8'h00));
        send_request(make_load(7'd2, 1'b0, 8'h04, 8'h7F));
        send_request(make_load(7'd3, 1'b1, 8'h00, 8'h01));
        send_request(make_load(7'd64, 1'b1, 8'h05, 8'h02));
        send_request(make_load(7'd127, 1'b1, 8'h01, 8'hFE));
        send_request(make_sample(16'hFFFF, 1'b0));
        send_request(make_sample(16'h8000, 1'b0));
        send_request(make_sample(16'hFFFF, 1'b0));
        send_request(make_sample(16'h7FFF, 1'b1));
        send_request(make_sample(16'h0000, 1'b1));
        send_request(make_sample(16'h7FFF, 1'b0));
        send_request(make_sample(16'h0000, 1'b0));
        send_request(make_sample(16'hFFFF, 1'b0));
        send_request(make_sample(16'hFFFF, 1'b1));

        // swapped halves at the lowest threshold
        drain();
        write_reg(REG_PRESS_LEVEL, 16'h0000);
        write_reg(REG_SWAP_SIDES, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_request(make_sample(16'h0000, 1'b1));

        // highest threshold, second key maps to a never written entry
        drain();
        write_reg(REG_PRESS_LEVEL, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_request(make_sample(16'hFFFF, 1'b0));
        send_request(make_sample(16'hFFFE, 1'b1));

        // random phases, each with its own register setting and pacing
        while (items_sent < ITEM_TARGET)
        begin
            drain();
            case ($urandom_range(0, 4))
                0:       thr = 16'h0000;
                1:       thr = 16'hFFFF;
                2:       thr = 16'($urandom_range(0, 255));
                default: thr = 16'($urandom_range(0, 65535));
            endcase
            swap = $urandom_range(0, 1);
            if ($urandom_range(0, 1))
            begin
                write_reg(REG_PRESS_LEVEL, thr);
                write_reg(REG_SWAP_SIDES, {15'($urandom_range(0, 32767)), swap});
            end
            else
            begin
                write_reg(REG_SWAP_SIDES, {15'($urandom_range(0, 32767)), swap});
                write_reg(REG_PRESS_LEVEL, thr);
            end
            cfg_valid <= 1'b0;
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);

            // refresh part of the keymap
            repeat ($urandom_range(8, 32)) send_request(random_load());

            repeat ($urandom_range(2, 6))
            begin
                // mostly short frames, some into the right half, a few past 256
                pick = $urandom_range(0, 99);
                if (frames_done % 10 == 3 || pick >= 95)
                    frame_len = $urandom_range(250, 300);
                else if (pick >= 65)
                    frame_len = $urandom_range(13, 130);
                else
                    frame_len = $urandom_range(1, 12);
                for (int k = 0; k < frame_len; k++)
                begin
                    // stray keymap loads in the middle of a frame
                    if ($urandom_range(0, 9) == 0)
                        send_request(random_load());
                    send_request(make_sample(pick_level(thr), k == frame_len - 1));
                end
                frames_done++;
            end
        end

        drain();
        if (board.mismatch_count == 0 && board.expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // report side with random stalls
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                report_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_ready <= 1'b1;
            @(posedge clk);
            while (!report_valid) @(posedge clk);
            board.check_report(report);
        end
    end

    // watchdog on cycles with no request, report or register write accepted
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (report_valid && report_ready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
